FILE: design/tlbrr_pkg.sv
`default_nettype none

package tlbrr_pkg;

	localparam int TLB_ENTRIES = 64;
	localparam int IDX_W       = $clog2(TLB_ENTRIES);
	localparam int PAGE_W      = 20;
	localparam int SLOT_W      = 6;
	localparam int WORD_W      = 32;
	localparam int OFFSET_W    = 12;
	localparam int OP_W        = 2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TLB_ENTRIES - 1);

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_INV_ONE = 2'd1;
	localparam logic [OP_W-1:0] OP_INV_ALL = 2'd2;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 136;

endpackage

`default_nettype wire

FILE: design/tlb_refill_round_robin_core.sv
`default_nettype none

// Round-robin TLB refill engine. Each transaction on the slave side carries one
// operation: load a translation, invalidate one page, or invalidate all entries.
// Load and invalidate-one walk the entry table one slot per cycle through a
// single tag memory read port and stop at the first free slot or the first
// valid matching tag; when no slot does (full table on load, or a miss), the
// walk runs through the last slot. Invalidate-all and unused operation codes
// skip the walk and go straight to the finish state. The slave side is ready
// again as the result appears. Valid bits live in flops and reset clears them
// at once, so no clearing pass is needed. A result waits in the master-side
// output register, and the next request is taken while it waits; that request
// holds its own result until the waiting one is taken.
module tlb_refill_round_robin_core
	import tlbrr_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// virtual_page[19:0], physical_page[39:20], read_only[40], zero fill[47:41]
	input  wire [IN_DATA_W-1:0]   s_tdata,
	// operation[1:0]
	input  wire [OP_W-1:0]        s_tuser,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// slot[5:0], replaced[6], matched[7], entry_hi[39:8], entry_lo[71:40],
	// free_load_count[103:72], replace_load_count[135:104]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [PAGE_W-1:0]      vpage_q;
	logic [PAGE_W-1:0]      ppage_q;
	logic                   ro_q;
	logic [IDX_W-1:0]       addr_q;
	logic                   issue_done_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [TLB_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]       victim_q;
	logic [WORD_W-1:0]      free_cnt_q;
	logic [WORD_W-1:0]      repl_cnt_q;

	logic [PAGE_W-1:0]      tag_rd_data;
	logic                   rd_en;
	logic                   hit_s1;
	logic                   last_s1;
	logic                   in_xfer;
	logic                   out_free;
	logic                   finish;
	logic                   is_load;
	logic                   do_replace;
	logic [IDX_W-1:0]       fin_idx;
	logic [IDX_W+SLOT_W-1:0] idx_ext;
	logic [SLOT_W-1:0]      res_slot;
	logic                   res_replaced;
	logic                   res_matched;
	logic [WORD_W-1:0]      res_hi;
	logic [WORD_W-1:0]      res_lo;
	logic [WORD_W-1:0]      free_cnt_nxt;
	logic [WORD_W-1:0]      repl_cnt_nxt;
	logic                   tag_we;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign finish   = (state_q == ST_FINISH) && out_free;
	assign rd_en    = (state_q == ST_SCAN) && !issue_done_q;

	assign hit_s1 = rd_vld_s1 && ((op_q == OP_LOAD) ? !valid_q[idx_s1]
		: (valid_q[idx_s1] && (tag_rd_data == vpage_q)));
	assign last_s1 = rd_vld_s1 && (idx_s1 == IDX_LAST);

	always_comb begin
		is_load      = (op_q == OP_LOAD);
		do_replace   = is_load && !found_q;
		fin_idx      = do_replace ? victim_q : hit_idx_q;
		idx_ext      = {{SLOT_W{1'b0}}, fin_idx};
		res_slot     = (is_load || ((op_q == OP_INV_ONE) && found_q))
			? idx_ext[SLOT_W-1:0] : '0;
		res_replaced = do_replace;
		res_matched  = (op_q == OP_INV_ONE) && found_q;
		res_hi       = is_load ? {vpage_q, {OFFSET_W{1'b0}}} : '0;
		res_lo       = is_load ? {ppage_q, 1'b0, !ro_q, 1'b1, 9'b0} : '0;
		free_cnt_nxt = free_cnt_q + WORD_W'(is_load && found_q);
		repl_cnt_nxt = repl_cnt_q + WORD_W'(do_replace);
		tag_we       = finish && is_load;
	end

	tlbrr_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(TLB_ENTRIES)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (tag_we),
		.wr_addr(fin_idx),
		.wr_data(vpage_q),
		.rd_en  (rd_en),
		.rd_addr(addr_q),
		.rd_data(tag_rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= s_tuser;
			vpage_q <= s_tdata[PAGE_W-1:0];
			ppage_q <= s_tdata[2*PAGE_W-1:PAGE_W];
			ro_q    <= s_tdata[2*PAGE_W];
		end
		if (rd_en) begin
			idx_s1 <= addr_q;
		end
		if (finish) begin
			m_tdata <= {repl_cnt_nxt, free_cnt_nxt, res_lo, res_hi,
				res_matched, res_replaced, res_slot};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			hit_idx_q    <= '0;
			valid_q      <= '0;
			victim_q     <= '0;
			free_cnt_q   <= '0;
			repl_cnt_q   <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (m_tvalid && m_tready && !finish) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						found_q      <= 1'b0;
						if ((s_tuser == OP_LOAD) || (s_tuser == OP_INV_ONE)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == IDX_LAST) begin
							issue_done_q <= 1'b1;
						end
					end
					if (hit_s1) begin
						found_q   <= 1'b1;
						hit_idx_q <= idx_s1;
						state_q   <= ST_FINISH;
					end else if (last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid   <= 1'b1;
						free_cnt_q <= free_cnt_nxt;
						repl_cnt_q <= repl_cnt_nxt;
						state_q    <= ST_IDLE;
						if (is_load) begin
							valid_q[fin_idx] <= 1'b1;
						end else if ((op_q == OP_INV_ONE) && found_q) begin
							valid_q[hit_idx_q] <= 1'b0;
						end else if (op_q == OP_INV_ALL) begin
							valid_q <= '0;
						end
						if (do_replace) begin
							victim_q <= (victim_q == IDX_LAST) ? '0 : victim_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("request accepted while a request was in progress");

	a_replace_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && do_replace) |-> (&valid_q))
		else $error("round-robin replacement with a free slot present");

	a_free_slot_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && is_load && found_q) |-> !valid_q[hit_idx_q])
		else $error("load into a slot that is already valid");

	a_inv_all_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && op_q == OP_INV_ALL) |=> (valid_q == '0))
		else $error("invalidate-all left valid entries");
`endif

endmodule

`default_nettype wire

FILE: design/tlbrr_ram.sv
`default_nettype none

module tlbrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
